// File: rtl/tiled_rgb5a3_ci8_texel_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Texel decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TILED_RGB5A3_CI8_TEXEL_DECODER_TOP_ASSERT_SVH
`define TILED_RGB5A3_CI8_TEXEL_DECODER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDEC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tdec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texel decoder package
// Item types, register and item-kind codes, defaults and shared helpers.
// ----------------------------------------------------------------------------
package tdec_pkg;

	localparam int DEF_PALETTE_ENTRIES = 256;
	localparam int DEF_MAX_WIDTH       = 128;
	localparam int DEF_MAX_HEIGHT      = 64;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [7:0] RST_IMAGE_WIDTH  = 8'd96;
	localparam logic [6:0] RST_IMAGE_HEIGHT = 7'd32;

	localparam logic FUNC_PALETTE_WRITE = 1'b0;
	localparam logic FUNC_TEXEL         = 1'b1;

	localparam logic FMT_RGB5A3 = 1'b0;
	localparam logic FMT_CI8    = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEX_FMT      = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic        func;
		logic [7:0]  palette_slot;
		logic [15:0] word_value;
	} texel_item_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [12:0] pixel_index;
		logic        last_pixel;
	} pixel_item_t;

	// Reduces a byte modulo the palette size by four conditional subtractions.
	// The palette must hold at least sixteen entries; the function does not check.
	function automatic logic [7:0] slot_mod(input logic [7:0] v, input int unsigned modulus);
		int unsigned r;
		r = 32'(v);
		for (int k = 3; k >= 0; k--) begin
			if (r >= (modulus << k)) begin
				r = r - (modulus << k);
			end
		end
		return r[7:0];
	endfunction

endpackage

// File: rtl/tdec_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tdec_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/tdec_pos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texel position tracker
// Holds the configuration registers and the tile counters, and places each
// texel in the vertically flipped image.
// ----------------------------------------------------------------------------
module tdec_pos #(
	parameter int MAX_WIDTH  = tdec_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = tdec_pkg::DEF_MAX_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tdec_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [tdec_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              step,
	output logic                              tex_fmt,
	output logic [$clog2(MAX_WIDTH+1)-1:0]    pos_x,
	output logic [$clog2(MAX_HEIGHT+1)-1:0]   pos_yf,
	output logic [$clog2(MAX_WIDTH+1)-1:0]    eff_width,
	output logic                              pos_last
);

	import tdec_pkg::*;

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int CWX = (WW > 8) ? WW : 8;
	localparam int CHX = (HW > 7) ? HW : 7;
	localparam int TCW = ($clog2(MAX_WIDTH / 4) > 0) ? $clog2(MAX_WIDTH / 4) : 1;
	localparam int TRW = ($clog2(MAX_HEIGHT / 4) > 0) ? $clog2(MAX_HEIGHT / 4) : 1;

	logic           fmt_q;
	logic [7:0]     width_q;
	logic [6:0]     height_q;
	logic [2:0]     col_q;
	logic [1:0]     row_q;
	logic [TCW-1:0] tcol_q;
	logic [TRW-1:0] trow_q;

	logic [CWX-1:0] w_ext;
	logic [CHX-1:0] h_ext;
	logic [WW-1:0]  w_cl;
	logic [HW-1:0]  h_cl;
	logic [WW-1:0]  across_raw;
	logic [WW-1:0]  across;
	logic [HW-1:0]  down_raw;
	logic [HW-1:0]  down;
	logic [WW-1:0]  w_eff;
	logic [HW-1:0]  h_eff;
	logic           out_of_range;
	logic [2:0]     col;
	logic [1:0]     row;
	logic [TCW-1:0] tcol;
	logic [TRW-1:0] trow;
	logic [2:0]     tw_m1;
	logic           end_col;
	logic           end_row;
	logic           end_tcol;
	logic           end_trow;
	logic [HW-1:0]  y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_RGB5A3;
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_TEX_FMT: begin
					fmt_q <= cfg_wdata[0];
				end
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_wdata[7:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_wdata[6:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		w_ext      = CWX'(width_q);
		h_ext      = CHX'(height_q);
		w_cl       = (w_ext > CWX'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_ext[WW-1:0];
		h_cl       = (h_ext > CHX'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : h_ext[HW-1:0];
		across_raw = (fmt_q == FMT_CI8) ? (w_cl >> 3) : (w_cl >> 2);
		across     = (across_raw == '0) ? WW'(1) : across_raw;
		down_raw   = h_cl >> 2;
		down       = (down_raw == '0) ? HW'(1) : down_raw;
		w_eff      = (fmt_q == FMT_CI8) ? (across << 3) : (across << 2);
		h_eff      = down << 2;
		tw_m1      = (fmt_q == FMT_CI8) ? 3'd7 : 3'd3;

		out_of_range = (col_q > tw_m1) || (WW'(tcol_q) >= across) || (HW'(trow_q) >= down);
		col  = out_of_range ? '0 : col_q;
		row  = out_of_range ? '0 : row_q;
		tcol = out_of_range ? '0 : tcol_q;
		trow = out_of_range ? '0 : trow_q;

		end_col  = (col == tw_m1);
		end_row  = (row == 2'd3);
		end_tcol = (WW'(tcol) == across - WW'(1));
		end_trow = (HW'(trow) == down - HW'(1));

		pos_x    = (fmt_q == FMT_CI8) ? WW'({tcol, col}) : WW'({tcol, col[1:0]});
		y        = HW'({trow, row});
		pos_yf   = h_eff - HW'(1) - y;
		pos_last = end_col && end_row && end_tcol && end_trow;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			tcol_q <= '0;
			trow_q <= '0;
		end else if (step) begin
			col_q  <= end_col ? '0 : col + 3'd1;
			row_q  <= end_col ? (end_row ? '0 : row + 2'd1) : row;
			tcol_q <= (end_col && end_row) ? (end_tcol ? '0 : tcol + TCW'(1)) : tcol;
			trow_q <= (end_col && end_row && end_tcol) ?
				(end_trow ? '0 : trow + TRW'(1)) : trow;
		end
	end

	assign tex_fmt   = fmt_q;
	assign eff_width = w_eff;

endmodule

// File: rtl/tdec_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel output stage
// Picks the palette or direct word, expands RGB5A3 to RGBA8, forms the pixel
// index and holds the finished item in the output register.
// ----------------------------------------------------------------------------
`include "tiled_rgb5a3_ci8_texel_decoder_top_assert.svh"

module tdec_out #(
	parameter int MAX_WIDTH  = tdec_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = tdec_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic                            tex_fmt,
	input  logic [15:0]                     word_value,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]  pos_x,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0] pos_yf,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]  eff_width,
	input  logic                            pos_last,
	input  logic [15:0]                     palette_word,
	output logic                            busy,
	output logic                            pixel_valid,
	input  logic                            pixel_stall,
	output tdec_pkg::pixel_item_t           pixel_item
);

	import tdec_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = WW + HW;

	logic          s1_valid_q;
	logic          s1_fmt_q;
	logic [15:0]   s1_word_q;
	logic [WW-1:0] s1_x_q;
	logic [HW-1:0] s1_yf_q;
	logic [WW-1:0] s1_w_q;
	logic          s1_last_q;

	logic          pixel_valid_q;
	pixel_item_t   pixel_item_q;

	logic          adv;
	logic          s1_en;
	logic [15:0]   sel_word;
	logic [PW-1:0] pix;
	logic [PW+12:0] pix_ext;
	pixel_item_t   dec;

	assign adv   = !pixel_valid_q || !pixel_stall;
	assign s1_en = !s1_valid_q || adv;
	assign busy  = s1_valid_q && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_en) begin
			s1_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && load) begin
			s1_fmt_q  <= tex_fmt;
			s1_word_q <= word_value;
			s1_x_q    <= pos_x;
			s1_yf_q   <= pos_yf;
			s1_w_q    <= eff_width;
			s1_last_q <= pos_last;
		end
	end

	always_comb begin
		sel_word = (s1_fmt_q == FMT_CI8) ? palette_word : s1_word_q;
		pix      = PW'(s1_yf_q) * PW'(s1_w_q) + PW'(s1_x_q);
		pix_ext  = {13'd0, pix};
		if (sel_word[15]) begin
			dec.red   = {sel_word[14:10], sel_word[14:12]};
			dec.green = {sel_word[9:5], sel_word[9:7]};
			dec.blue  = {sel_word[4:0], sel_word[4:2]};
			dec.alpha = 8'hFF;
		end else begin
			dec.red   = {sel_word[11:8], sel_word[11:8]};
			dec.green = {sel_word[7:4], sel_word[7:4]};
			dec.blue  = {sel_word[3:0], sel_word[3:0]};
			dec.alpha = {sel_word[14:12], sel_word[14:12], sel_word[14:13]};
		end
		dec.pixel_index = pix_ext[12:0];
		dec.last_pixel  = s1_last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid_q <= 1'b0;
		end else if (adv) begin
			pixel_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			pixel_item_q <= dec;
		end
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel_item  = pixel_item_q;

	`TDEC_ASSERT_NEXT(a_s1_held, s1_valid_q && !adv, s1_valid_q && $stable(s1_word_q), "Item moved.")
	`TDEC_ASSERT_NEXT(a_s1_delivered, s1_valid_q && adv, pixel_valid_q, "Item not delivered.")
	`TDEC_ASSERT_SAME(a_out_source, $rose(pixel_valid_q), $past(s1_valid_q), "Item without source.")

endmodule

// File: rtl/tiled_rgb5a3_ci8_texel_decoder_top.sv
`timescale 1ns / 1ps
// The decoder takes one item per clock cycle and keeps that rate indefinitely
// while the output side is not stalled. The clock edge that accepts a texel
// item also reads the palette and loads the first stage register; the pixel
// moves to the output register when that can advance, after colour expansion
// and the pixel index multiply. The palette memory's read port is registered.
// Palette writes take the memory's write port in their own cycle and produce
// no item, so a texel may read an entry written by the item just before it.
// The input is stalled only while the output register holds an untaken pixel
// and the stage behind it is full. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
// Tiled RGB5A3 / CI8 texel decoder
// Turns a tiled texture stream into RGBA8 pixels with flipped row-major index.
// ----------------------------------------------------------------------------
module tiled_rgb5a3_ci8_texel_decoder_top #(
	parameter int PALETTE_ENTRIES = tdec_pkg::DEF_PALETTE_ENTRIES,
	parameter int MAX_WIDTH       = tdec_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT      = tdec_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            texel_valid,
	output logic                            texel_stall,
	input  tdec_pkg::texel_item_t           texel_item,
	output logic                            pixel_valid,
	input  logic                            pixel_stall,
	output tdec_pkg::pixel_item_t           pixel_item,
	input  logic                            cfg_we,
	input  logic [tdec_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tdec_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	import tdec_pkg::*;

	localparam int PAW = $clog2(PALETTE_ENTRIES);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);

	logic           accept;
	logic           pal_we;
	logic           texel_acc;
	logic [PAW-1:0] pal_waddr;
	logic [PAW-1:0] pal_raddr;
	logic [15:0]    pal_rdata;
	logic           tex_fmt;
	logic [WW-1:0]  pos_x;
	logic [HW-1:0]  pos_yf;
	logic [WW-1:0]  eff_width;
	logic           pos_last;
	logic           busy;

	assign accept    = texel_valid && !texel_stall;
	assign pal_we    = accept && (texel_item.func == FUNC_PALETTE_WRITE);
	assign texel_acc = accept && (texel_item.func == FUNC_TEXEL);
	assign pal_waddr = PAW'(slot_mod(texel_item.palette_slot, PALETTE_ENTRIES));
	assign pal_raddr = PAW'(slot_mod(texel_item.word_value[7:0], PALETTE_ENTRIES));
	assign texel_stall = busy;

	tdec_ram #(
		.WIDTH(16),
		.DEPTH(PALETTE_ENTRIES)
	) u_pal_ram (
		.clk  (clk),
		.we   (pal_we),
		.waddr(pal_waddr),
		.wdata(texel_item.word_value),
		.re   (texel_acc),
		.raddr(pal_raddr),
		.rdata(pal_rdata)
	);

	tdec_pos #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.step        (texel_acc),
		.tex_fmt     (tex_fmt),
		.pos_x       (pos_x),
		.pos_yf      (pos_yf),
		.eff_width   (eff_width),
		.pos_last    (pos_last)
	);

	tdec_out #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (texel_acc),
		.tex_fmt     (tex_fmt),
		.word_value  (texel_item.word_value),
		.pos_x       (pos_x),
		.pos_yf      (pos_yf),
		.eff_width   (eff_width),
		.pos_last    (pos_last),
		.palette_word(pal_rdata),
		.busy        (busy),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_item  (pixel_item)
	);

endmodule
